// ===== design/assert_macros.svh =====
// Assertion shorthands used by the RTL.
// Each macro takes a label, a clock, a reset (active low), a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence holds in the same cycle as the condition
`define OWBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("owbm assertion failed");

// Consequence holds in the cycle after the condition
`define OWBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("owbm assertion failed");

`endif

// ===== design/owbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_pkg
// Types, codes and constants of the single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int unsigned TICK_W = 10;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned BIT_IDX_W = 3;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [TICK_W-1:0] WRITE_ONE_RECOVERY = 10'd64;
	localparam logic [TICK_W-1:0] WRITE_ZERO_RECOVERY = 10'd9;

	// Request codes carried on req_type
	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_RESET  = 3'd1,
		REQ_WRITE  = 3'd2,
		REQ_RDBYTE = 3'd3,
		REQ_RDBIT  = 3'd4
	} req_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RESET_LOW     = 3'd0,
		CFG_PRESENCE_WAIT = 3'd1,
		CFG_RESET_TAIL    = 3'd2,
		CFG_READ_LOW      = 3'd3,
		CFG_READ_SAMPLE   = 3'd4,
		CFG_READ_TAIL     = 3'd5,
		CFG_WRITE_ONE_LOW = 3'd6,
		CFG_WRITE_ZERO_LOW = 3'd7
	} cfg_idx_t;

	localparam logic [TICK_W-1:0] RESET_LOW_DEFAULT      = 10'd500;
	localparam logic [TICK_W-1:0] PRESENCE_WAIT_DEFAULT  = 10'd50;
	localparam logic [TICK_W-1:0] RESET_TAIL_DEFAULT     = 10'd480;
	localparam logic [TICK_W-1:0] READ_LOW_DEFAULT       = 10'd7;
	localparam logic [TICK_W-1:0] READ_SAMPLE_DEFAULT    = 10'd9;
	localparam logic [TICK_W-1:0] READ_TAIL_DEFAULT      = 10'd55;
	localparam logic [TICK_W-1:0] WRITE_ONE_LOW_DEFAULT  = 10'd7;
	localparam logic [TICK_W-1:0] WRITE_ZERO_LOW_DEFAULT = 10'd60;

	// Bus phases
	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_TAIL = 4'd3,
		PH_RD_LOW   = 4'd4,
		PH_RD_WAIT  = 4'd5,
		PH_RD_TAIL  = 4'd6,
		PH_WR_LOW   = 4'd7,
		PH_WR_REC   = 4'd8
	} phase_t;

	// Operation in progress
	typedef enum logic [1:0] {
		OP_RESET  = 2'd0,
		OP_WRITE  = 2'd1,
		OP_RDBYTE = 2'd2,
		OP_RDBIT  = 2'd3
	} op_t;

	// Timing registers as seen by the sequencer
	typedef struct packed {
		logic [TICK_W-1:0] reset_low;
		logic [TICK_W-1:0] presence_wait;
		logic [TICK_W-1:0] reset_tail;
		logic [TICK_W-1:0] read_low;
		logic [TICK_W-1:0] read_sample;
		logic [TICK_W-1:0] read_tail;
		logic [TICK_W-1:0] write_one_low;
		logic [TICK_W-1:0] write_zero_low;
	} timing_t;

	// One input request
	typedef struct packed {
		logic [2:0]        req_type;
		logic [BYTE_W-1:0] write_data;
		logic              line_sample;
	} item_t;

	// One result
	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_data;
		logic              presence;
		logic              bus_fault;
		logic              rejected;
	} result_t;

endpackage

// ===== design/onewire_bus_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_bus_master
// Single-wire bus master stepped by requests: reset with presence detect,
// byte write, byte read and bit read, timed by tick requests.
// A taken request passes the input register, then the sequencer into the result
// register, which raises out_valid.
// Throughput: one request per cycle while the result channel does not stall;
// the sequencer updates all state in the cycle the request leaves the input
// register.
// Reset: arst_n clears the sequencer to idle and loads default timings.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module onewire_bus_master #(
	parameter logic [owbm_pkg::TICK_W-1:0] WRITE_ONE_RECOVERY  = owbm_pkg::WRITE_ONE_RECOVERY,
	parameter logic [owbm_pkg::TICK_W-1:0] WRITE_ZERO_RECOVERY = owbm_pkg::WRITE_ZERO_RECOVERY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         req_type,
	input  logic [owbm_pkg::BYTE_W-1:0]        write_data,
	input  logic                               line_sample,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               drive_low,
	output logic                               busy_res,
	output logic                               done_res,
	output logic [owbm_pkg::BYTE_W-1:0]        read_data,
	output logic                               presence,
	output logic                               bus_fault,
	output logic                               rejected,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [owbm_pkg::TICK_W-1:0]        cfg_data
);

	logic               valid_s1;
	owbm_pkg::item_t    item_s1;
	logic               out_valid_q;
	owbm_pkg::result_t  res_q;
	owbm_pkg::result_t  res_next;
	owbm_pkg::timing_t  timing;
	logic               out_free;
	logic               step;
	logic               in_fire;

	// Handshake: the input stage moves on when the result register is free
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_fire  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Hold the request in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.req_type    <= req_type;
			item_s1.write_data  <= write_data;
			item_s1.line_sample <= line_sample;
		end
	end

	owbm_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.timing   (timing)
	);

	owbm_core #(
		.WRITE_ONE_RECOVERY  (WRITE_ONE_RECOVERY),
		.WRITE_ZERO_RECOVERY (WRITE_ZERO_RECOVERY)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.timing (timing),
		.result (res_next)
	);

	// Result register: load on a step, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_next;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_low = res_q.drive_low;
	assign busy_res  = res_q.busy_res;
	assign done_res  = res_q.done_res;
	assign read_data = res_q.read_data;
	assign presence  = res_q.presence;
	assign bus_fault = res_q.bus_fault;
	assign rejected  = res_q.rejected;

	// A rejected request only happens while an operation runs
	`OWBM_ASSERT_SAME(a_reject_busy, clk, arst_n, out_valid_q && res_q.rejected, res_q.busy_res && !res_q.done_res)
	// Completion leaves the bus released and idle
	`OWBM_ASSERT_SAME(a_done_idle, clk, arst_n, out_valid_q && res_q.done_res, !res_q.busy_res && !res_q.drive_low)
	// A stalled input always has a request waiting in the input register
	`OWBM_ASSERT_SAME(a_stall_held, clk, arst_n, in_stall, valid_s1 && out_valid_q)
	// Every step lands in the result register
	`OWBM_ASSERT_NEXT(a_step_lands, clk, arst_n, step, out_valid_q)

endmodule

// ===== design/owbm_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_regs
// Timing register file, written through the configuration port.
// ----------------------------------------------------------------------------
module owbm_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [owbm_pkg::TICK_W-1:0]          wr_data,
	output owbm_pkg::timing_t                    timing
);

	owbm_pkg::timing_t timing_q;

	// Load defaults on reset, update the addressed register on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.reset_low      <= owbm_pkg::RESET_LOW_DEFAULT;
			timing_q.presence_wait  <= owbm_pkg::PRESENCE_WAIT_DEFAULT;
			timing_q.reset_tail     <= owbm_pkg::RESET_TAIL_DEFAULT;
			timing_q.read_low       <= owbm_pkg::READ_LOW_DEFAULT;
			timing_q.read_sample    <= owbm_pkg::READ_SAMPLE_DEFAULT;
			timing_q.read_tail      <= owbm_pkg::READ_TAIL_DEFAULT;
			timing_q.write_one_low  <= owbm_pkg::WRITE_ONE_LOW_DEFAULT;
			timing_q.write_zero_low <= owbm_pkg::WRITE_ZERO_LOW_DEFAULT;
		end else if (wr_en) begin
			unique case (owbm_pkg::cfg_idx_t'(wr_index))
				owbm_pkg::CFG_RESET_LOW:      timing_q.reset_low      <= wr_data;
				owbm_pkg::CFG_PRESENCE_WAIT:  timing_q.presence_wait  <= wr_data;
				owbm_pkg::CFG_RESET_TAIL:     timing_q.reset_tail     <= wr_data;
				owbm_pkg::CFG_READ_LOW:       timing_q.read_low       <= wr_data;
				owbm_pkg::CFG_READ_SAMPLE:    timing_q.read_sample    <= wr_data;
				owbm_pkg::CFG_READ_TAIL:      timing_q.read_tail      <= wr_data;
				owbm_pkg::CFG_WRITE_ONE_LOW:  timing_q.write_one_low  <= wr_data;
				owbm_pkg::CFG_WRITE_ZERO_LOW: timing_q.write_zero_low <= wr_data;
				default: ;
			endcase
		end
	end

	assign timing = timing_q;

endmodule

// ===== design/owbm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_core
// Bus phase sequencer: applies one request per cycle, when step is set, to
// the bus state and forms its result.
// ----------------------------------------------------------------------------
module owbm_core #(
	parameter logic [owbm_pkg::TICK_W-1:0] WRITE_ONE_RECOVERY  = owbm_pkg::WRITE_ONE_RECOVERY,
	parameter logic [owbm_pkg::TICK_W-1:0] WRITE_ZERO_RECOVERY = owbm_pkg::WRITE_ZERO_RECOVERY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  owbm_pkg::item_t   item,
	input  owbm_pkg::timing_t timing,
	output owbm_pkg::result_t result
);

	owbm_pkg::phase_t                    phase_q, phase_n;
	owbm_pkg::op_t                       op_q, op_n;
	logic [owbm_pkg::TICK_W-1:0]         tick_q, tick_n;
	logic [owbm_pkg::BIT_IDX_W-1:0]      bit_q, bit_n;
	logic [owbm_pkg::BYTE_W-1:0]         shift_q, shift_n;
	logic                                presence_q, presence_n;
	logic                                drive_q, drive_n;

	logic                                cur_bit;
	logic [owbm_pkg::TICK_W-1:0]         raw_len;
	logic [owbm_pkg::TICK_W-1:0]         phase_len;
	logic [owbm_pkg::TICK_W:0]           tick_inc;
	logic                                done;
	logic                                fault;
	logic                                rej;
	logic                                is_read;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= owbm_pkg::PH_IDLE;
			op_q       <= owbm_pkg::OP_RESET;
			tick_q     <= '0;
			bit_q      <= '0;
			shift_q    <= '0;
			presence_q <= 1'b0;
			drive_q    <= 1'b0;
		end else begin
			phase_q    <= phase_n;
			op_q       <= op_n;
			tick_q     <= tick_n;
			bit_q      <= bit_n;
			shift_q    <= shift_n;
			presence_q <= presence_n;
			drive_q    <= drive_n;
		end
	end

	// Length of the current phase; a zero length counts as one tick
	assign cur_bit = shift_q[bit_q];

	always_comb begin
		unique case (phase_q)
			owbm_pkg::PH_RST_LOW:  raw_len = timing.reset_low;
			owbm_pkg::PH_RST_WAIT: raw_len = timing.presence_wait;
			owbm_pkg::PH_RST_TAIL: raw_len = timing.reset_tail;
			owbm_pkg::PH_RD_LOW:   raw_len = timing.read_low;
			owbm_pkg::PH_RD_WAIT:  raw_len = timing.read_sample;
			owbm_pkg::PH_RD_TAIL:  raw_len = timing.read_tail;
			owbm_pkg::PH_WR_LOW:
				raw_len = cur_bit ? timing.write_one_low : timing.write_zero_low;
			owbm_pkg::PH_WR_REC:
				raw_len = cur_bit ? WRITE_ONE_RECOVERY : WRITE_ZERO_RECOVERY;
			default:               raw_len = {{(owbm_pkg::TICK_W-1){1'b0}}, 1'b1};
		endcase
	end

	assign phase_len = (raw_len == '0) ? {{(owbm_pkg::TICK_W-1){1'b0}}, 1'b1} : raw_len;
	assign tick_inc  = {1'b0, tick_q} + {{owbm_pkg::TICK_W{1'b0}}, 1'b1};

	// Next state for one request
	always_comb begin
		phase_n    = phase_q;
		op_n       = op_q;
		tick_n     = tick_q;
		bit_n      = bit_q;
		shift_n    = shift_q;
		presence_n = presence_q;
		drive_n    = drive_q;
		done       = 1'b0;
		fault      = 1'b0;
		rej        = 1'b0;

		if (step) begin
			case (owbm_pkg::req_t'(item.req_type)) inside
				owbm_pkg::REQ_RESET, owbm_pkg::REQ_WRITE,
				owbm_pkg::REQ_RDBYTE, owbm_pkg::REQ_RDBIT: begin
					if (phase_q != owbm_pkg::PH_IDLE) begin
						rej = 1'b1;
					end else begin
						bit_n   = '0;
						tick_n  = '0;
						drive_n = 1'b1;
						case (owbm_pkg::req_t'(item.req_type))
							owbm_pkg::REQ_RESET: begin
								op_n       = owbm_pkg::OP_RESET;
								presence_n = 1'b0;
								phase_n    = owbm_pkg::PH_RST_LOW;
							end
							owbm_pkg::REQ_WRITE: begin
								op_n    = owbm_pkg::OP_WRITE;
								shift_n = item.write_data;
								phase_n = owbm_pkg::PH_WR_LOW;
							end
							owbm_pkg::REQ_RDBYTE: begin
								op_n    = owbm_pkg::OP_RDBYTE;
								shift_n = '0;
								phase_n = owbm_pkg::PH_RD_LOW;
							end
							default: begin
								op_n    = owbm_pkg::OP_RDBIT;
								shift_n = '0;
								phase_n = owbm_pkg::PH_RD_LOW;
							end
						endcase
					end
				end
				owbm_pkg::REQ_TICK: begin
					if (phase_q != owbm_pkg::PH_IDLE) begin
						if (tick_inc < {1'b0, phase_len}) begin
							tick_n = tick_inc[owbm_pkg::TICK_W-1:0];
						end else begin
							// Phase over: clear the counter, release the bus unless the next bit starts
							tick_n  = '0;
							drive_n = 1'b0;
							unique case (phase_q)
								owbm_pkg::PH_RST_LOW: phase_n = owbm_pkg::PH_RST_WAIT;
								owbm_pkg::PH_RST_WAIT: begin
									presence_n = ~item.line_sample;
									phase_n    = owbm_pkg::PH_RST_TAIL;
								end
								owbm_pkg::PH_RST_TAIL: begin
									fault   = ~item.line_sample;
									done    = 1'b1;
									phase_n = owbm_pkg::PH_IDLE;
								end
								owbm_pkg::PH_RD_LOW: phase_n = owbm_pkg::PH_RD_WAIT;
								owbm_pkg::PH_RD_WAIT: begin
									if (item.line_sample) begin
										shift_n[bit_q] = 1'b1;
									end
									phase_n = owbm_pkg::PH_RD_TAIL;
								end
								owbm_pkg::PH_RD_TAIL: begin
									if (op_q == owbm_pkg::OP_RDBYTE && bit_q != '1) begin
										bit_n   = bit_q + 1'b1;
										drive_n = 1'b1;
										phase_n = owbm_pkg::PH_RD_LOW;
									end else begin
										done    = 1'b1;
										phase_n = owbm_pkg::PH_IDLE;
									end
								end
								owbm_pkg::PH_WR_LOW: phase_n = owbm_pkg::PH_WR_REC;
								owbm_pkg::PH_WR_REC: begin
									if (bit_q != '1) begin
										bit_n   = bit_q + 1'b1;
										drive_n = 1'b1;
										phase_n = owbm_pkg::PH_WR_LOW;
									end else begin
										done    = 1'b1;
										phase_n = owbm_pkg::PH_IDLE;
									end
								end
								default: phase_n = owbm_pkg::PH_IDLE;
							endcase
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Result fields from the updated state
	assign is_read = (op_q == owbm_pkg::OP_RDBYTE) || (op_q == owbm_pkg::OP_RDBIT);

	always_comb begin
		result.drive_low = drive_n;
		result.busy_res  = (phase_n != owbm_pkg::PH_IDLE);
		result.done_res  = done;
		result.read_data = (done && is_read) ? shift_n : '0;
		result.presence  = done && (op_q == owbm_pkg::OP_RESET) && presence_n;
		result.bus_fault = done && (op_q == owbm_pkg::OP_RESET) && fault;
		result.rejected  = rej;
	end

endmodule

// ===== tb/onewire_bus_master_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_bus_master_checker
// Watches the request, result and configuration channels of the single-wire
// bus master. Keeps its own copy of the bus sequencer and timing registers,
// works out the result of every accepted request and compares each accepted
// result, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module onewire_bus_master_checker
	import owbm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [2:0]           req_type,
	input  logic [BYTE_W-1:0]    write_data,
	input  logic                 line_sample,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 drive_low,
	input  logic                 busy_res,
	input  logic                 done_res,
	input  logic [BYTE_W-1:0]    read_data,
	input  logic                 presence,
	input  logic                 bus_fault,
	input  logic                 rejected,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	// Sequencer copy
	phase_t               bus_phase;
	op_t                  bus_op;
	logic [TICK_W-1:0]    tick_count;
	logic [BIT_IDX_W-1:0] bit_pos;
	logic [BYTE_W-1:0]    shift_byte;
	logic                 presence_seen;
	logic                 drive_state;
	logic [TICK_W-1:0]    timing [8];

	// Results owed by the block, oldest first
	result_t pending_bus_results [$];

	task automatic enter_phase(input phase_t ph, input logic low);
		bus_phase = ph;
		tick_count = '0;
		drive_state = low;
	endtask

	// Apply one request to the sequencer copy and queue the result it owes
	task automatic advance_bus(input logic [2:0] req, input logic [BYTE_W-1:0] data,
			input logic line);
		int unsigned len;
		logic finished;
		logic fault;
		logic refused;
		logic cur_bit;
		result_t owed;
		finished = 1'b0;
		fault = 1'b0;
		refused = 1'b0;
		case (req) inside
			REQ_RESET, REQ_WRITE, REQ_RDBYTE, REQ_RDBIT: begin
				if (bus_phase != PH_IDLE) begin
					refused = 1'b1;
				end else begin
					bit_pos = '0;
					case (req)
						REQ_RESET: begin
							bus_op = OP_RESET;
							presence_seen = 1'b0;
							enter_phase(PH_RST_LOW, 1'b1);
						end
						REQ_WRITE: begin
							bus_op = OP_WRITE;
							shift_byte = data;
							enter_phase(PH_WR_LOW, 1'b1);
						end
						default: begin
							bus_op = (req == REQ_RDBYTE) ? OP_RDBYTE : OP_RDBIT;
							shift_byte = '0;
							enter_phase(PH_RD_LOW, 1'b1);
						end
					endcase
				end
			end
			REQ_TICK: begin
				if (bus_phase != PH_IDLE) begin
					// length of the current phase; zero counts as one tick
					cur_bit = shift_byte[bit_pos];
					case (bus_phase)
						PH_RST_LOW:  len = timing[CFG_RESET_LOW];
						PH_RST_WAIT: len = timing[CFG_PRESENCE_WAIT];
						PH_RST_TAIL: len = timing[CFG_RESET_TAIL];
						PH_RD_LOW:   len = timing[CFG_READ_LOW];
						PH_RD_WAIT:  len = timing[CFG_READ_SAMPLE];
						PH_RD_TAIL:  len = timing[CFG_READ_TAIL];
						PH_WR_LOW:   len = cur_bit ? timing[CFG_WRITE_ONE_LOW] :
							timing[CFG_WRITE_ZERO_LOW];
						PH_WR_REC:   len = cur_bit ? WRITE_ONE_RECOVERY : WRITE_ZERO_RECOVERY;
						default:     len = 1;
					endcase
					if (len == 0)
						len = 1;
					if (32'(tick_count) + 1 < len) begin
						tick_count = tick_count + 1'b1;
					end else begin
						case (bus_phase)
							PH_RST_LOW: enter_phase(PH_RST_WAIT, 1'b0);
							PH_RST_WAIT: begin
								presence_seen = !line;
								enter_phase(PH_RST_TAIL, 1'b0);
							end
							PH_RST_TAIL: begin
								fault = !line;
								enter_phase(PH_IDLE, 1'b0);
								finished = 1'b1;
							end
							PH_RD_LOW: enter_phase(PH_RD_WAIT, 1'b0);
							PH_RD_WAIT: begin
								if (line)
									shift_byte[bit_pos] = 1'b1;
								enter_phase(PH_RD_TAIL, 1'b0);
							end
							PH_RD_TAIL: begin
								if (bus_op == OP_RDBYTE && bit_pos < 3'd7) begin
									bit_pos = bit_pos + 1'b1;
									enter_phase(PH_RD_LOW, 1'b1);
								end else begin
									enter_phase(PH_IDLE, 1'b0);
									finished = 1'b1;
								end
							end
							PH_WR_LOW: enter_phase(PH_WR_REC, 1'b0);
							PH_WR_REC: begin
								if (bit_pos < 3'd7) begin
									bit_pos = bit_pos + 1'b1;
									enter_phase(PH_WR_LOW, 1'b1);
								end else begin
									enter_phase(PH_IDLE, 1'b0);
									finished = 1'b1;
								end
							end
							default: enter_phase(PH_IDLE, 1'b0);
						endcase
					end
				end
			end
			default: ;
		endcase

		owed.drive_low = drive_state;
		owed.busy_res = (bus_phase != PH_IDLE);
		owed.done_res = finished;
		owed.read_data = (finished && (bus_op == OP_RDBYTE || bus_op == OP_RDBIT)) ?
			shift_byte : '0;
		owed.presence = finished && bus_op == OP_RESET && presence_seen;
		owed.bus_fault = finished && bus_op == OP_RESET && fault;
		owed.rejected = refused;
		pending_bus_results.push_back(owed);
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Retire results first, then take new requests and register writes
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			bus_phase = PH_IDLE;
			bus_op = OP_RESET;
			tick_count = '0;
			bit_pos = '0;
			shift_byte = '0;
			presence_seen = 1'b0;
			drive_state = 1'b0;
			timing[CFG_RESET_LOW] = RESET_LOW_DEFAULT;
			timing[CFG_PRESENCE_WAIT] = PRESENCE_WAIT_DEFAULT;
			timing[CFG_RESET_TAIL] = RESET_TAIL_DEFAULT;
			timing[CFG_READ_LOW] = READ_LOW_DEFAULT;
			timing[CFG_READ_SAMPLE] = READ_SAMPLE_DEFAULT;
			timing[CFG_READ_TAIL] = READ_TAIL_DEFAULT;
			timing[CFG_WRITE_ONE_LOW] = WRITE_ONE_LOW_DEFAULT;
			timing[CFG_WRITE_ZERO_LOW] = WRITE_ZERO_LOW_DEFAULT;
			pending_bus_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_bus_results.size() == 0) begin
					$error("result accepted with no request waiting");
					mismatches++;
				end else begin
					want = pending_bus_results.pop_front();
					check_field("drive_low", want.drive_low, drive_low);
					check_field("busy_res", want.busy_res, busy_res);
					check_field("done_res", want.done_res, done_res);
					check_field("read_data", want.read_data, read_data);
					check_field("presence", want.presence, presence);
					check_field("bus_fault", want.bus_fault, bus_fault);
					check_field("rejected", want.rejected, rejected);
				end
			end
			if (in_valid && !in_stall)
				advance_bus(req_type, write_data, line_sample);
			if (cfg_valid && cfg_ready)
				timing[cfg_index] = cfg_data;
			outstanding = pending_bus_results.size();
		end
	end

endmodule

// ===== tb/onewire_bus_master_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_bus_master_tb
// Drives the single-wire bus master with directed and random command and
// tick requests under several timing settings, with random idle and stall
// bursts on both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module onewire_bus_master_tb;

	import owbm_pkg::*;

	localparam int REQ_CODE_MAX = 7;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [2:0]           req_type;
	logic [BYTE_W-1:0]    write_data;
	logic                 line_sample;
	logic                 out_valid;
	logic                 out_stall;
	logic                 drive_low;
	logic                 busy_res;
	logic                 done_res;
	logic [BYTE_W-1:0]    read_data;
	logic                 presence;
	logic                 bus_fault;
	logic                 rejected;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;
	int                   mismatches;
	int                   outstanding;

	// Idle bursts on both sides while set
	logic gaps_on = 1'b1;
	int   work_items;

	// Timing the stimulus believes is loaded
	logic [TICK_W-1:0] timing_set [8] = '{RESET_LOW_DEFAULT, PRESENCE_WAIT_DEFAULT,
		RESET_TAIL_DEFAULT, READ_LOW_DEFAULT, READ_SAMPLE_DEFAULT, READ_TAIL_DEFAULT,
		WRITE_ONE_LOW_DEFAULT, WRITE_ZERO_LOW_DEFAULT};

	onewire_bus_master DUT (.*);

	onewire_bus_master_checker bus_check (.*);

	always #5 clk = ~clk;

	// Offer one request, after an optional idle burst, and hold it until taken
	task automatic send_request(input logic [2:0] req, input logic [BYTE_W-1:0] data,
			input logic line);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		write_data <= data;
		line_sample <= line;
		do @(posedge clk); while (in_stall);
	endtask

	// Write every timing register from timing_set
	task automatic load_timing();
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= timing_set[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Drop the request valid and wait for the block to drain
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic int unsigned slot_ticks(input int idx);
		return (timing_set[idx] == 0) ? 1 : timing_set[idx];
	endfunction

	// Ticks an operation needs from its command to its completion
	function automatic int unsigned ticks_for(input logic [2:0] op,
			input logic [BYTE_W-1:0] data);
		int unsigned total;
		total = 0;
		case (op)
			REQ_RESET: total = slot_ticks(CFG_RESET_LOW) + slot_ticks(CFG_PRESENCE_WAIT) +
				slot_ticks(CFG_RESET_TAIL);
			REQ_RDBIT: total = slot_ticks(CFG_READ_LOW) + slot_ticks(CFG_READ_SAMPLE) +
				slot_ticks(CFG_READ_TAIL);
			REQ_RDBYTE: total = 8 * (slot_ticks(CFG_READ_LOW) + slot_ticks(CFG_READ_SAMPLE) +
				slot_ticks(CFG_READ_TAIL));
			REQ_WRITE: begin
				for (int b = 0; b < 8; b++)
					total += data[b] ? slot_ticks(CFG_WRITE_ONE_LOW) + WRITE_ONE_RECOVERY :
						slot_ticks(CFG_WRITE_ZERO_LOW) + WRITE_ZERO_RECOVERY;
			end
			default: total = 0;
		endcase
		return total;
	endfunction

	// Run one operation to completion; when noisy, maybe interrupt it with a
	// command, sprinkle unknown requests and maybe trail some idle ticks
	task automatic run_op(input logic [2:0] op, input logic [BYTE_W-1:0] data,
			input bit noisy);
		int unsigned n;
		int cut;
		n = ticks_for(op, data);
		cut = -1;
		if (noisy && $urandom_range(0, 2) == 0)
			cut = $urandom_range(0, n - 1);
		send_request(op, data, 1'($urandom));
		for (int k = 0; k < n; k++) begin
			if (k == cut)
				send_request(3'($urandom_range(REQ_RESET, REQ_RDBIT)), 8'($urandom),
					1'($urandom));
			if (noisy && $urandom_range(0, 15) == 0)
				send_request(3'($urandom_range(REQ_RDBIT + 1, REQ_CODE_MAX)), 8'($urandom),
					1'($urandom));
			send_request(REQ_TICK, 8'($urandom), 1'($urandom));
		end
		if (noisy && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_request(REQ_TICK, 8'($urandom), 1'($urandom));
		work_items += n + 1;
	endtask

	// Result side back-pressure
	initial begin : result_backpressure
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		logic [2:0] op;
		int phase_start;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_TICK;
		write_data <= '0;
		line_sample <= 1'b1;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_RESET_LOW;
		cfg_data <= '0;
		work_items = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read a bit with the timing left by reset
		run_op(REQ_RDBIT, 8'h00, 1'b0);

		// zero lengths everywhere: each timed phase but write recovery lasts one tick
		settle();
		foreach (timing_set[i])
			timing_set[i] = '0;
		load_timing();

		// idle tick and unknown requests change nothing
		send_request(REQ_TICK, 8'hFF, 1'b0);
		for (int k = REQ_RDBIT + 1; k <= REQ_CODE_MAX; k++)
			send_request(3'(k), 8'h00, 1'b1);

		// reset with presence seen and the line stuck low after the tail
		send_request(REQ_RESET, 8'h00, 1'b0);
		send_request(REQ_TICK, 8'h00, 1'b1);
		send_request(REQ_TICK, 8'h00, 1'b0);
		send_request(REQ_TICK, 8'h00, 1'b0);

		// reset with no device, every command refused while it runs
		send_request(REQ_RESET, 8'h00, 1'b1);
		send_request(REQ_RESET, 8'h00, 1'b0);
		send_request(REQ_WRITE, 8'hFF, 1'b0);
		send_request(REQ_RDBYTE, 8'h00, 1'b1);
		send_request(REQ_RDBIT, 8'h00, 1'b0);
		send_request(3'(REQ_CODE_MAX), 8'h00, 1'b0);
		repeat (3) send_request(REQ_TICK, 8'h00, 1'b1);

		// read a high bit, then a byte, then a write of zeros ending on a one
		send_request(REQ_RDBIT, 8'h00, 1'b0);
		repeat (3) send_request(REQ_TICK, 8'h00, 1'b1);
		run_op(REQ_RDBYTE, 8'h00, 1'b0);
		run_op(REQ_WRITE, 8'h80, 1'b0);

		// random operations under short random timings; no idle or stall bursts in the last one
		for (int p = 0; p < 3; p++) begin
			settle();
			gaps_on = (p != 2);
			foreach (timing_set[i])
				timing_set[i] = TICK_W'($urandom_range(0, 6));
			load_timing();
			phase_start = work_items;
			while (work_items - phase_start < 30) begin
				if ($urandom_range(0, 4) == 0)
					send_request($urandom_range(0, 4) == 0 ?
						3'($urandom_range(REQ_RDBIT + 1, REQ_CODE_MAX)) : REQ_TICK,
						8'($urandom), 1'($urandom));
				case ($urandom_range(0, 8))
					0, 1, 2: op = REQ_RESET;
					3, 4, 5: op = REQ_RDBIT;
					6, 7:    op = REQ_RDBYTE;
					default: op = REQ_WRITE;
				endcase
				// keep writes short: only the last bit may be a one
				run_op(op, (op == REQ_WRITE) ? {1'($urandom), 7'h00} : 8'($urandom), 1'b1);
			end
		end

		// drain and give the verdict
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/owbm_pkg.sv
design/owbm_regs.sv
design/owbm_core.sv
design/onewire_bus_master.sv
tb/onewire_bus_master_checker.sv
tb/onewire_bus_master_tb.sv
